// ===== hdl/apool_pkg.sv =====
// ----------------------------------------------------------------------------
// Average pooling package
// Shared widths, codes, state encoding and control bundles of the average
// pooling engine.
// ----------------------------------------------------------------------------
package apool_pkg;

   // Field and register widths fixed by the interface.
   localparam int SAMPLE_W   = 16;
   localparam int RECIP_W    = 17;
   localparam int RECIP_ONE  = 65536;
   localparam int ROWIN_W    = 5;
   localparam int CH_W       = 4;
   localparam int DIM_W      = 6;
   localparam int CHN_W      = 5;
   localparam int KER_W      = 4;
   localparam int MAX_STRIDE = 8;
   localparam int IDX_W      = 9;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   // Item function codes.
   localparam logic FUNC_WRITE   = 1'b0;
   localparam logic FUNC_REQUEST = 1'b1;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_IN_HEIGHT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IN_WIDTH     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNELS     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_H     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_W     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STRIDE_H     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_STRIDE_W     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_RECIP = 3'd7;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_MUL,
      ST_OUT
   } apool_state_type;

   // Map and window geometry seen by the sequencer.
   typedef struct packed {
      logic [DIM_W-1:0] in_height;
      logic [DIM_W-1:0] in_width;
      logic [CHN_W-1:0] channels;
      logic [KER_W-1:0] kernel_h;
      logic [KER_W-1:0] kernel_w;
      logic [KER_W-1:0] stride_h;
      logic [KER_W-1:0] stride_w;
   } apool_cfg_type;

   // Commands from the sequencer to the accumulate and scale unit.
   typedef struct packed {
      logic clear;
      logic tap;
      logic scale;
      logic finish;
   } apool_ctrl_type;

endpackage

// ===== hdl/average_pooling_engine.sv =====
// ----------------------------------------------------------------------------
// Average pooling engine
// 2D average pooling over one channel-interleaved feature map held in an
// internal sample store.
//
// Usage: an item is taken when start is high and busy is low. A write item
// (func 0) stores one Q8.8 sample at row, col, channel and never raises
// busy; writes outside the configured map are dropped. A request item
// (func 1) raises busy while the sequencer steps through one window tap per
// cycle, reading each tap inside the map from the single read port of the
// store into a shared accumulator; then state DRAIN takes in the last read,
// MUL multiplies by window_recip and OUT shifts and saturates. The average
// appears on rsp_average with rsp_valid for exactly one cycle, in the first
// cycle busy is low again, so a new item may be taken there. The receiver
// cannot stall the block. Reset returns the sequencer to idle and loads the
// register defaults; the store is not cleared, and each sample must be written
// before a request reads it. The user is to write registers over the APB-style
// port only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module average_pooling_engine #(
   parameter int MAX_HEIGHT   = 32,
   parameter int MAX_WIDTH    = 32,
   parameter int MAX_CHANNELS = 16,
   parameter int MAX_KERNEL   = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_func,
   input  logic [apool_pkg::ROWIN_W-1:0]         req_row,
   input  logic [apool_pkg::ROWIN_W-1:0]         req_col,
   input  logic [apool_pkg::CH_W-1:0]            req_channel,
   input  logic signed [apool_pkg::SAMPLE_W-1:0] req_value,
   output logic                                  rsp_valid,
   output logic signed [apool_pkg::SAMPLE_W-1:0] rsp_average,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [apool_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [apool_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [apool_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                  pready
);
   import apool_pkg::*;

   localparam int DEPTH  = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SUM_W  = SAMPLE_W + $clog2(MAX_KERNEL * MAX_KERNEL);

   localparam logic [DIM_W-1:0] RST_HEIGHT   = DIM_W'((MAX_HEIGHT < 32) ? MAX_HEIGHT : 32);
   localparam logic [DIM_W-1:0] RST_WIDTH    = DIM_W'((MAX_WIDTH < 32) ? MAX_WIDTH : 32);
   localparam logic [CHN_W-1:0] RST_CHANNELS =
      CHN_W'((MAX_CHANNELS < 16) ? MAX_CHANNELS : 16);
   localparam logic [KER_W-1:0] RST_KERNEL   = KER_W'((MAX_KERNEL < 2) ? MAX_KERNEL : 2);
   localparam logic [KER_W-1:0] RST_STRIDE   = KER_W'(2);
   localparam logic [RECIP_W-1:0] RST_RECIP  = RECIP_W'(16384);

   logic [DIM_W-1:0]   in_height_ff, in_height_in;
   logic [DIM_W-1:0]   in_width_ff, in_width_in;
   logic [CHN_W-1:0]   channels_ff, channels_in;
   logic [KER_W-1:0]   kernel_h_ff, kernel_h_in;
   logic [KER_W-1:0]   kernel_w_ff, kernel_w_in;
   logic [KER_W-1:0]   stride_h_ff, stride_h_in;
   logic [KER_W-1:0]   stride_w_ff, stride_w_in;
   logic [RECIP_W-1:0] recip_ff, recip_in;

   logic                  csr_wr;
   logic [CSR_IDX_W-1:0]  csr_idx;
   logic                  item_take;
   logic                  req_go;
   logic                  wr_in_map;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [IDX_W-1:0]      tap_row;
   logic [IDX_W-1:0]      tap_col;
   logic [CH_W-1:0]       tap_ch;
   logic [IDX_W-1:0]      sel_row;
   logic [IDX_W-1:0]      sel_col;
   logic [CH_W-1:0]       sel_ch;
   logic [ADDR_W-1:0]     ram_addr;
   logic [SAMPLE_W-1:0]   ram_rd_data;
   apool_cfg_type         cfg;
   apool_ctrl_type        ctrl;

   // Clamp a size or stride field to the range one through hi.
   function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int hi);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > hi) begin
         r = DIM_W'(hi);
      end
      return r;
   endfunction

   // Register port decode.
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[CSR_ADDR_W-1:2];

   // Register writes with range clamping.
   always_comb begin
      in_height_in = in_height_ff;
      in_width_in  = in_width_ff;
      channels_in  = channels_ff;
      kernel_h_in  = kernel_h_ff;
      kernel_w_in  = kernel_w_ff;
      stride_h_in  = stride_h_ff;
      stride_w_in  = stride_w_ff;
      recip_in     = recip_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_IN_HEIGHT: in_height_in = clamp_dim(pwdata[DIM_W-1:0], MAX_HEIGHT);
            REG_IN_WIDTH:  in_width_in  = clamp_dim(pwdata[DIM_W-1:0], MAX_WIDTH);
            REG_CHANNELS:
               channels_in = CHN_W'(clamp_dim(DIM_W'(pwdata[CHN_W-1:0]), MAX_CHANNELS));
            REG_KERNEL_H:
               kernel_h_in = KER_W'(clamp_dim(DIM_W'(pwdata[KER_W-1:0]), MAX_KERNEL));
            REG_KERNEL_W:
               kernel_w_in = KER_W'(clamp_dim(DIM_W'(pwdata[KER_W-1:0]), MAX_KERNEL));
            REG_STRIDE_H:
               stride_h_in = KER_W'(clamp_dim(DIM_W'(pwdata[KER_W-1:0]), MAX_STRIDE));
            REG_STRIDE_W:
               stride_w_in = KER_W'(clamp_dim(DIM_W'(pwdata[KER_W-1:0]), MAX_STRIDE));
            REG_WINDOW_RECIP: begin
               if (int'(pwdata[RECIP_W-1:0]) > RECIP_ONE) begin
                  recip_in = RECIP_W'(RECIP_ONE);
               end else begin
                  recip_in = pwdata[RECIP_W-1:0];
               end
            end
            default: recip_in = recip_ff;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (csr_idx)
         REG_IN_HEIGHT:    prdata = CSR_DATA_W'(in_height_ff);
         REG_IN_WIDTH:     prdata = CSR_DATA_W'(in_width_ff);
         REG_CHANNELS:     prdata = CSR_DATA_W'(channels_ff);
         REG_KERNEL_H:     prdata = CSR_DATA_W'(kernel_h_ff);
         REG_KERNEL_W:     prdata = CSR_DATA_W'(kernel_w_ff);
         REG_STRIDE_H:     prdata = CSR_DATA_W'(stride_h_ff);
         REG_STRIDE_W:     prdata = CSR_DATA_W'(stride_w_ff);
         REG_WINDOW_RECIP: prdata = CSR_DATA_W'(recip_ff);
         default:          prdata = '0;
      endcase
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_height_ff <= RST_HEIGHT;
         in_width_ff  <= RST_WIDTH;
         channels_ff  <= RST_CHANNELS;
         kernel_h_ff  <= RST_KERNEL;
         kernel_w_ff  <= RST_KERNEL;
         stride_h_ff  <= RST_STRIDE;
         stride_w_ff  <= RST_STRIDE;
         recip_ff     <= RST_RECIP;
      end else begin
         in_height_ff <= in_height_in;
         in_width_ff  <= in_width_in;
         channels_ff  <= channels_in;
         kernel_h_ff  <= kernel_h_in;
         kernel_w_ff  <= kernel_w_in;
         stride_h_ff  <= stride_h_in;
         stride_w_ff  <= stride_w_in;
         recip_ff     <= recip_in;
      end
   end

   assign cfg.in_height = in_height_ff;
   assign cfg.in_width  = in_width_ff;
   assign cfg.channels  = channels_ff;
   assign cfg.kernel_h  = kernel_h_ff;
   assign cfg.kernel_w  = kernel_w_ff;
   assign cfg.stride_h  = stride_h_ff;
   assign cfg.stride_w  = stride_w_ff;

   // Item acceptance and write filtering.
   assign item_take = start && !busy;
   assign req_go    = item_take && (req_func == FUNC_REQUEST);
   assign wr_in_map = (DIM_W'(req_row) < in_height_ff) && (DIM_W'(req_col) < in_width_ff)
                      && (CHN_W'(req_channel) < channels_ff);
   assign ram_wr_en = item_take && (req_func == FUNC_WRITE) && wr_in_map;

   // Store address: writes use the item fields, reads the current tap.
   assign sel_row  = busy ? tap_row : IDX_W'(req_row);
   assign sel_col  = busy ? tap_col : IDX_W'(req_col);
   assign sel_ch   = busy ? tap_ch : req_channel;
   assign ram_addr = (ADDR_W'(sel_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(sel_col))
                     * ADDR_W'(MAX_CHANNELS) + ADDR_W'(sel_ch);

   apool_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .go      (req_go),
      .row     (req_row),
      .col     (req_col),
      .channel (req_channel),
      .cfg     (cfg),
      .busy    (busy),
      .rd_en   (ram_rd_en),
      .tap_row (tap_row),
      .tap_col (tap_col),
      .tap_ch  (tap_ch),
      .ctrl    (ctrl)
   );

   apool_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (req_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   apool_acc #(
      .SUM_W (SUM_W)
   ) u_acc (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .rd_data      ($signed(ram_rd_data)),
      .window_recip (recip_ff),
      .rsp_valid    (rsp_valid),
      .rsp_average  (rsp_average)
   );

   // A result is a single-cycle strobe.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // The result shows only once the sequencer is idle again.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while a request is still running");

   // The store is never written while a window is being read.
   a_no_wr_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !ram_wr_en)
      else $error("store written during a window scan");

   // An accepted request always starts the sequencer.
   a_req_starts: assert property (@(posedge clock) disable iff (reset)
      req_go |=> busy)
      else $error("accepted request did not start the sequencer");

endmodule

// ===== hdl/apool_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module apool_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/apool_scan.sv =====
// ----------------------------------------------------------------------------
// Average pooling window sequencer
// Walks the taps of one pooling window, one per cycle, and steps the shared
// accumulator through sum, scale and result.
// ----------------------------------------------------------------------------
module apool_scan (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            go,
   input  logic [apool_pkg::ROWIN_W-1:0]   row,
   input  logic [apool_pkg::ROWIN_W-1:0]   col,
   input  logic [apool_pkg::CH_W-1:0]      channel,
   input  apool_pkg::apool_cfg_type        cfg,
   output logic                            busy,
   output logic                            rd_en,
   output logic [apool_pkg::IDX_W-1:0]     tap_row,
   output logic [apool_pkg::IDX_W-1:0]     tap_col,
   output logic [apool_pkg::CH_W-1:0]      tap_ch,
   output apool_pkg::apool_ctrl_type       ctrl
);
   import apool_pkg::*;

   apool_state_type   state_ff, state_in;
   logic [IDX_W-1:0]  base_row_ff, base_row_in;
   logic [IDX_W-1:0]  base_col_ff, base_col_in;
   logic [CH_W-1:0]   ch_ff, ch_in;
   logic              ch_ok_ff, ch_ok_in;
   logic [KER_W-1:0]  kh_ff, kh_in;
   logic [KER_W-1:0]  kw_ff, kw_in;
   logic              tap_ff, tap_in;
   logic              last_col;
   logic              last_tap;
   logic              tap_ok;

   // Current tap position and whether it lies inside the map.
   assign tap_row  = base_row_ff + IDX_W'(kh_ff);
   assign tap_col  = base_col_ff + IDX_W'(kw_ff);
   assign tap_ch   = ch_ff;
   assign tap_ok   = ch_ok_ff && (tap_row < IDX_W'(cfg.in_height))
                     && (tap_col < IDX_W'(cfg.in_width));
   assign last_col = (kw_ff == cfg.kernel_w - 4'd1);
   assign last_tap = last_col && (kh_ff == cfg.kernel_h - 4'd1);

   // Window origin and tap counters.
   always_comb begin
      base_row_in = base_row_ff;
      base_col_in = base_col_ff;
      ch_in       = ch_ff;
      ch_ok_in    = ch_ok_ff;
      kh_in       = kh_ff;
      kw_in       = kw_ff;
      if (go) begin
         base_row_in = IDX_W'(row) * IDX_W'(cfg.stride_h);
         base_col_in = IDX_W'(col) * IDX_W'(cfg.stride_w);
         ch_in       = channel;
         ch_ok_in    = (CHN_W'(channel) < cfg.channels);
         kh_in       = '0;
         kw_in       = '0;
      end else if (state_ff == ST_SCAN) begin
         if (last_col) begin
            kw_in = '0;
            kh_in = kh_ff + 4'd1;
         end else begin
            kw_in = kw_ff + 4'd1;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_MUL;
         ST_MUL:   state_in = ST_OUT;
         ST_OUT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      busy        = (state_ff != ST_IDLE);
      rd_en       = (state_ff == ST_SCAN) && tap_ok;
      tap_in      = rd_en;
      ctrl.clear  = go;
      ctrl.tap    = tap_ff;
      ctrl.scale  = (state_ff == ST_MUL);
      ctrl.finish = (state_ff == ST_OUT);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
      end
   end

   // Window registers.
   always_ff @(posedge clock) begin
      base_row_ff <= base_row_in;
      base_col_ff <= base_col_in;
      ch_ff       <= ch_in;
      ch_ok_ff    <= ch_ok_in;
      kh_ff       <= kh_in;
      kw_ff       <= kw_in;
   end

endmodule

// ===== hdl/apool_acc.sv =====
// ----------------------------------------------------------------------------
// Average pooling accumulate and scale unit
// Adds window samples one per cycle, scales the sum by the Q1.16 reciprocal
// and saturates the floor-shifted product to a Q8.8 average.
// ----------------------------------------------------------------------------
module apool_acc #(
   parameter int SUM_W = 22
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  apool_pkg::apool_ctrl_type            ctrl,
   input  logic signed [apool_pkg::SAMPLE_W-1:0] rd_data,
   input  logic [apool_pkg::RECIP_W-1:0]        window_recip,
   output logic                                 rsp_valid,
   output logic signed [apool_pkg::SAMPLE_W-1:0] rsp_average
);
   import apool_pkg::*;

   localparam int PROD_W = SUM_W + RECIP_W + 1;
   localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(32767);
   localparam logic signed [PROD_W-1:0] SAT_LO = -PROD_W'(32768);

   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [RECIP_W:0]    recip_s;
   logic signed [PROD_W-1:0]   shifted;
   logic signed [SAMPLE_W-1:0] avg_ff, avg_in;
   logic                       valid_ff;

   // Running window sum.
   always_comb begin
      sum_in = sum_ff;
      if (ctrl.clear) begin
         sum_in = '0;
      end else if (ctrl.tap) begin
         sum_in = sum_ff + SUM_W'(rd_data);
      end
   end

   // Scale by the reciprocal of the window size.
   assign recip_s = $signed({1'b0, window_recip});
   always_comb begin
      prod_in = prod_ff;
      if (ctrl.scale) begin
         prod_in = PROD_W'(sum_ff) * PROD_W'(recip_s);
      end
   end

   // Floor shift by 16 and saturate to Q8.8.
   assign shifted = prod_ff >>> 16;
   always_comb begin
      if (shifted > SAT_HI) begin
         avg_in = SAMPLE_W'(SAT_HI);
      end else if (shifted < SAT_LO) begin
         avg_in = SAMPLE_W'(SAT_LO);
      end else begin
         avg_in = SAMPLE_W'(shifted);
      end
   end

   // Result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctrl.finish;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      prod_ff <= prod_in;
      if (ctrl.finish) begin
         avg_ff <= avg_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_average = avg_ff;

endmodule
